// ===== rtl/binary_frame_receiver_crc32_macros.svh =====
// Assertion macros shared by the checker of the binary frame receiver.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BINARY_FRAME_RECEIVER_CRC32_MACROS_SVH
`define BINARY_FRAME_RECEIVER_CRC32_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define BFR_ASSERT_IMPLY(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while dis is high.
`define BFR_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/bfr_pkg.sv =====
// Package for the binary frame receiver: beat types, mode type, codes and
// the nibble-table CRC-32 functions. No dependencies.
package bfr_pkg;

  localparam int unsigned LIMIT_W = 17;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [3:0] opcode;
    logic       last;
    logic       crc_good;
    logic [2:0] fault_code;
    logic       error_active;
  } out_item_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_HEADER  = 3'd1,
    MODE_PAYLOAD = 3'd2,
    MODE_ERROR   = 3'd3,
    MODE_RESYNC  = 3'd4
  } mode_t;

  // Input actions.
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Latched error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_START = 3'd1;
  localparam logic [2:0] ERR_TEXT      = 3'd2;
  localparam logic [2:0] ERR_OVERSIZE  = 3'd3;
  localparam logic [2:0] ERR_CRC       = 3'd4;

  // Link byte values.
  localparam logic [7:0] BYTE_START   = 8'h01;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] BYTE_TAB     = 8'h09;
  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_LBRACE  = 8'h7B;
  localparam logic [7:0] BYTE_LBRACK  = 8'h5B;
  localparam logic [7:0] LEN_EXT16    = 8'd126;
  localparam logic [7:0] LEN_EXT64    = 8'd127;

  // Header lengths for the three length forms.
  localparam logic [3:0] HDR_LEN_SHORT = 4'd7;
  localparam logic [3:0] HDR_LEN_EXT16 = 4'd9;
  localparam logic [3:0] HDR_LEN_EXT64 = 4'd15;

  // Header byte positions.
  localparam logic [LIMIT_W-1:0] POS_OPCODE    = LIMIT_W'(1);
  localparam logic [LIMIT_W-1:0] POS_CRC_FIRST = LIMIT_W'(2);
  localparam logic [LIMIT_W-1:0] POS_CRC_LAST  = LIMIT_W'(5);
  localparam logic [LIMIT_W-1:0] POS_LENGTH    = LIMIT_W'(6);

  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = LIMIT_W'(4096);

  // Reflected CRC-32 nibble table (polynomial 0xEDB88320).
  function automatic logic [31:0] crc_nibble(input logic [3:0] idx);
    logic [31:0] v;
    case (idx)
      4'h0: v = 32'h00000000;
      4'h1: v = 32'h1db71064;
      4'h2: v = 32'h3b6e20c8;
      4'h3: v = 32'h26d930ac;
      4'h4: v = 32'h76dc4190;
      4'h5: v = 32'h6b6b51f4;
      4'h6: v = 32'h4db26158;
      4'h7: v = 32'h5005713c;
      4'h8: v = 32'hedb88320;
      4'h9: v = 32'hf00f9344;
      4'hA: v = 32'hd6d6a3e8;
      4'hB: v = 32'hcb61b38c;
      4'hC: v = 32'h9b64c2b0;
      4'hD: v = 32'h86d3d2d4;
      4'hE: v = 32'ha00ae278;
      4'hF: v = 32'hbdbdf21c;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // One byte through the CRC, low nibble first.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] t;
    t = crc_nibble(c[3:0] ^ b[3:0]) ^ (c >> 4);
    t = crc_nibble(t[3:0] ^ b[7:4]) ^ (t >> 4);
    return t;
  endfunction

endpackage

// ===== rtl/bfr_core.sv =====
// Frame state and the per-beat decision logic of the binary frame receiver.
// Depends on bfr_pkg.
module bfr_core
  import bfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  in_item_t            item,
  input  logic [LIMIT_W-1:0]  frame_limit,
  output out_item_t           result_next
);

  // Frame state.
  mode_t                mode, mode_next;
  logic [LIMIT_W-1:0]   byte_count, byte_count_next;
  logic [3:0]           header_length, header_length_next;
  // Low bits of the payload length, plus a sticky flag for any higher bit.
  logic [LIMIT_W-1:0]   pl_low, pl_low_next;
  logic                 pl_big, pl_big_next;
  logic [LIMIT_W-1:0]   frame_end, frame_end_next;
  logic [31:0]          expected_crc, expected_crc_next;
  logic [31:0]          running_crc, running_crc_next;
  logic [3:0]           frame_opcode, frame_opcode_next;
  logic [2:0]           latched_error, latched_error_next;

  // Working values.
  logic [7:0]           b;
  logic [7:0]           crc_in;
  logic [31:0]          crc_step;
  logic [LIMIT_W:0]     hdr_total;
  logic                 dv, lst, good;
  logic [7:0]           db;

  assign b = item.rx_byte;

  // CRC field bytes are taken as zero.
  assign crc_in   = (mode == MODE_HEADER && byte_count >= POS_CRC_FIRST &&
                     byte_count <= POS_CRC_LAST) ? 8'h00 : b;
  assign crc_step = crc_byte(running_crc, crc_in);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      byte_count    <= '0;
      header_length <= HDR_LEN_SHORT;
      pl_low        <= '0;
      pl_big        <= 1'b0;
      frame_end     <= '0;
      expected_crc  <= '0;
      running_crc   <= '0;
      frame_opcode  <= '0;
      latched_error <= ERR_NONE;
    end else if (step_en) begin
      mode          <= mode_next;
      byte_count    <= byte_count_next;
      header_length <= header_length_next;
      pl_low        <= pl_low_next;
      pl_big        <= pl_big_next;
      frame_end     <= frame_end_next;
      expected_crc  <= expected_crc_next;
      running_crc   <= running_crc_next;
      frame_opcode  <= frame_opcode_next;
      latched_error <= latched_error_next;
    end
  end

  // Next state and result for one beat.
  always_comb begin
    mode_next          = mode;
    byte_count_next    = byte_count;
    header_length_next = header_length;
    pl_low_next        = pl_low;
    pl_big_next        = pl_big;
    frame_end_next     = frame_end;
    expected_crc_next  = expected_crc;
    running_crc_next   = running_crc;
    frame_opcode_next  = frame_opcode;
    latched_error_next = latched_error;
    hdr_total          = '0;
    dv                 = 1'b0;
    db                 = 8'h00;
    lst                = 1'b0;
    good               = 1'b0;

    if (item.action == ACT_CLEAR) begin
      latched_error_next = ERR_NONE;
      byte_count_next    = '0;
      mode_next          = MODE_RESYNC;
    end else begin
      case (mode)
        MODE_IDLE: begin
          if (b == BYTE_START) begin
            mode_next          = MODE_HEADER;
            byte_count_next    = LIMIT_W'(1);
            header_length_next = HDR_LEN_SHORT;
            pl_low_next        = '0;
            pl_big_next        = 1'b0;
            expected_crc_next  = '0;
            running_crc_next   = crc_byte(32'h0, b);
          end else if (b == BYTE_SPACE || b == BYTE_TAB || b == BYTE_LF ||
                       b == BYTE_CR) begin
            mode_next = MODE_IDLE;
          end else if (b == BYTE_LBRACE || b == BYTE_LBRACK) begin
            latched_error_next = ERR_TEXT;
            mode_next          = MODE_ERROR;
          end else begin
            latched_error_next = ERR_BAD_START;
            mode_next          = MODE_ERROR;
          end
        end

        MODE_HEADER: begin
          running_crc_next = crc_step;
          if (byte_count == POS_OPCODE) begin
            frame_opcode_next = b[3:0];
          end else if (byte_count >= POS_CRC_FIRST && byte_count <= POS_CRC_LAST) begin
            expected_crc_next = {expected_crc[23:0], b};
          end else if (byte_count == POS_LENGTH) begin
            pl_big_next = 1'b0;
            if (b == LEN_EXT16) begin
              header_length_next = HDR_LEN_EXT16;
              pl_low_next        = '0;
            end else if (b == LEN_EXT64) begin
              header_length_next = HDR_LEN_EXT64;
              pl_low_next        = '0;
            end else begin
              pl_low_next = LIMIT_W'(b);
            end
          end else begin
            // Extension byte: bits leaving the low field set the big flag.
            pl_big_next = pl_big | (|pl_low[LIMIT_W-1:LIMIT_W-8]);
            pl_low_next = {pl_low[LIMIT_W-9:0], b};
          end
          byte_count_next = byte_count + LIMIT_W'(1);
          hdr_total = {1'b0, pl_low_next} + (LIMIT_W+1)'(header_length_next);

          // Header complete: size check, then empty frame or payload.
          if (byte_count_next >= LIMIT_W'(header_length_next)) begin
            frame_end_next = hdr_total[LIMIT_W-1:0];
            if (pl_big_next || hdr_total >= {1'b0, frame_limit}) begin
              latched_error_next = ERR_OVERSIZE;
              mode_next          = MODE_ERROR;
            end else if (pl_low_next == '0) begin
              lst  = 1'b1;
              good = (crc_step == expected_crc_next);
              if (good) begin
                mode_next = MODE_IDLE;
              end else begin
                latched_error_next = ERR_CRC;
                mode_next          = MODE_ERROR;
              end
            end else begin
              mode_next = MODE_PAYLOAD;
            end
          end
        end

        MODE_PAYLOAD: begin
          running_crc_next = crc_step;
          byte_count_next  = byte_count + LIMIT_W'(1);
          dv = 1'b1;
          db = b;
          if (byte_count_next >= frame_end) begin
            lst  = 1'b1;
            good = (crc_step == expected_crc);
            if (good) begin
              mode_next = MODE_IDLE;
            end else begin
              latched_error_next = ERR_CRC;
              mode_next          = MODE_ERROR;
            end
          end
        end

        MODE_RESYNC: begin
          if (b == BYTE_LF || b == BYTE_CR) begin
            mode_next = MODE_IDLE;
          end
        end

        MODE_ERROR: begin
          mode_next = MODE_ERROR;
        end

        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
    end

    result_next.data_valid   = dv;
    result_next.data_byte    = db;
    result_next.opcode       = frame_opcode_next;
    result_next.last         = lst;
    result_next.crc_good     = good;
    result_next.fault_code   = latched_error_next;
    result_next.error_active = (latched_error_next != ERR_NONE);
  end

endmodule

// ===== rtl/binary_frame_receiver_crc32.sv =====
// Top level of the binary frame receiver with CRC-32 check.
// Depends on bfr_pkg and bfr_core.
//
// Usage:
// - item channel (item_valid/item_ready/item): one beat per link byte or
//   clear action. A clear drops any latched error and discards bytes up to
//   the next CR or LF before frames are looked for again.
// - result channel (result_valid/result_ready/result): exactly one beat
//   for every item beat, in order, carrying the payload byte if any, the
//   frame opcode, the end-of-frame mark with its CRC verdict and the error
//   latch.
// - cfg channel (cfg_valid/cfg_ready/cfg_data): writes frame_limit; it is
//   always ready; the user must write it only while the block is idle, which the block itself does not enforce.
// An accepted beat is loaded into the input register; once the result register
// is free or draining, the beat is carried through the CRC and header logic into
// the result register. Throughput is one item per cycle while result_ready is not
// held low; the frame state is updated on every beat, so back-to-back bytes are
// never held up by the CRC loop. Reset empties both registers, sets
// frame_limit to 4096 and returns the receiver to idle with no error. A
// stalled result holds the result register; the input register then fills
// and item_ready falls.
module binary_frame_receiver_crc32
  import bfr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  in_item_t           item,
  output logic               result_valid,
  input  logic               result_ready,
  output out_item_t          result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  logic [LIMIT_W-1:0] frame_limit;
  logic               s1_valid;
  in_item_t           s1_item;
  logic               s1_adv;
  out_item_t          result_next;

  // The input beat moves on whenever the result register is free or draining.
  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_adv;
  assign cfg_ready  = 1'b1;

  // Control registers and the frame limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      frame_limit  <= FRAME_LIMIT_RESET;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (!result_valid || result_ready) begin
        result_valid <= s1_valid;
      end
      if (cfg_valid && cfg_ready) begin
        frame_limit <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
    if (s1_adv) begin
      result <= result_next;
    end
  end

  bfr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step_en     (s1_adv),
    .item        (s1_item),
    .frame_limit (frame_limit),
    .result_next (result_next)
  );

endmodule

// ===== rtl/bfr_checker.sv =====
// Port-level checks on the binary frame receiver's result channel, bound to
// the top level. Depends on bfr_pkg and the shared assertion macros.
`include "binary_frame_receiver_crc32_macros.svh"

module bfr_checker
  import bfr_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_ready,
  input out_item_t result
);

  // A stalled result beat stays in place.
  `BFR_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready,
                   result_valid && $stable(result))

  // The CRC verdict only appears on the end of a frame.
  `BFR_ASSERT_IMPLY(a_good_needs_last, clk, rst, result_valid && result.crc_good,
                    result.last)

  // No payload byte means a zero data field.
  `BFR_ASSERT_IMPLY(a_idle_byte_zero, clk, rst, result_valid && !result.data_valid,
                    result.data_byte == 8'h00)

  // The error flag follows the latched code.
  `BFR_ASSERT_IMPLY(a_error_flag, clk, rst, result_valid,
                    result.error_active == (result.fault_code != ERR_NONE))

  // Reset leaves no result pending.
  `BFR_ASSERT_IMPLY(a_reset_empty, clk, 1'b0, $past(rst), !result_valid)

endmodule

bind binary_frame_receiver_crc32 bfr_checker u_bfr_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for binary_frame_receiver_crc32: directed beats from a stimulus
// table, then random framed traffic checked against a cycle-free frame predictor.
// Depends on bfr_pkg and the RTL of the receiver only.
module testbench
  import bfr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam int PHASE_ITEMS = 230;
  localparam int HOLD_CYCLES = 60;

  typedef struct {
    in_item_t  beat;
    bit        pinned;
    out_item_t want;
  } steer_row_t;

  logic               clk;
  logic               rst;
  logic               item_valid = 1'b0;
  logic               item_ready;
  in_item_t           item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  out_item_t          result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  // Predictor state, a private copy of the receiver's frame state.
  mode_t              p_mode;
  logic [16:0]        p_count;
  logic [3:0]         p_hdr_len;
  logic [63:0]        p_pay_len;
  logic [31:0]        p_exp_crc;
  logic [31:0]        p_run_crc;
  logic [3:0]         p_opcode;
  logic [2:0]         p_err;
  logic [LIMIT_W-1:0] p_limit;

  out_item_t   pending_results[$];
  logic [7:0]  frame_q[$];
  steer_row_t  steer_rows[$];

  int send_idle_pct = 7;
  int recv_idle_pct = 84;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  int items_sent = 0;
  int results_seen = 0;
  int failures = 0;
  int good_frames = 0;
  int bad_crc_frames = 0;
  int payload_beats = 0;
  int error_beats = 0;

  binary_frame_receiver_crc32 dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reflected CRC-32, one bit at a time, least significant bit first.
  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic void latch_fault(input logic [2:0] code);
    p_err  = code;
    p_mode = MODE_ERROR;
  endfunction

  function automatic void reset_model();
    p_mode    = MODE_IDLE;
    p_count   = '0;
    p_hdr_len = HDR_LEN_SHORT;
    p_pay_len = '0;
    p_exp_crc = '0;
    p_run_crc = '0;
    p_opcode  = '0;
    p_err     = ERR_NONE;
    p_limit   = FRAME_LIMIT_RESET;
  endfunction

  // Advances the predictor by one beat and returns the result beat it causes.
  function automatic out_item_t rx_predict(input in_item_t it);
    out_item_t   o;
    logic [7:0]  b;
    logic [16:0] pos;
    logic [64:0] total;
    o = '0;
    b = it.rx_byte;
    if (it.action == ACT_CLEAR) begin
      p_err   = ERR_NONE;
      p_count = '0;
      p_mode  = MODE_RESYNC;
    end else begin
      case (p_mode)
        MODE_IDLE: begin
          if (b == BYTE_START) begin
            p_mode    = MODE_HEADER;
            p_count   = 17'd1;
            p_hdr_len = HDR_LEN_SHORT;
            p_pay_len = '0;
            p_exp_crc = '0;
            p_run_crc = crc32_step(32'd0, b);
          end else if (b == BYTE_SPACE || b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR) begin
            // Whitespace between frames is skipped.
          end else if (b == BYTE_LBRACE || b == BYTE_LBRACK) begin
            latch_fault(ERR_TEXT);
          end else begin
            latch_fault(ERR_BAD_START);
          end
        end
        MODE_HEADER: begin
          pos = p_count;
          if (pos == POS_OPCODE) begin
            p_opcode  = b[3:0];
            p_run_crc = crc32_step(p_run_crc, b);
          end else if (pos >= POS_CRC_FIRST && pos <= POS_CRC_LAST) begin
            p_exp_crc = {p_exp_crc[23:0], b};
            p_run_crc = crc32_step(p_run_crc, 8'h00);
          end else if (pos == POS_LENGTH) begin
            p_run_crc = crc32_step(p_run_crc, b);
            if (b == LEN_EXT16) begin
              p_hdr_len = HDR_LEN_EXT16;
              p_pay_len = '0;
            end else if (b == LEN_EXT64) begin
              p_hdr_len = HDR_LEN_EXT64;
              p_pay_len = '0;
            end else begin
              p_pay_len = {56'd0, b};
            end
          end else begin
            p_run_crc = crc32_step(p_run_crc, b);
            p_pay_len = {p_pay_len[55:0], b};
          end
          p_count = p_count + 17'd1;
          if (p_count >= {13'd0, p_hdr_len}) begin
            total = {61'd0, p_hdr_len} + {1'b0, p_pay_len};
            if (p_pay_len >= {47'd0, p_limit} || total >= {48'd0, p_limit}) begin
              latch_fault(ERR_OVERSIZE);
            end else if (p_pay_len == 64'd0) begin
              // Empty payload: the frame closes on the last header beat.
              o.last     = 1'b1;
              o.crc_good = (p_run_crc == p_exp_crc);
              if (o.crc_good) p_mode = MODE_IDLE;
              else latch_fault(ERR_CRC);
            end else begin
              p_mode = MODE_PAYLOAD;
            end
          end
        end
        MODE_PAYLOAD: begin
          p_run_crc    = crc32_step(p_run_crc, b);
          p_count      = p_count + 17'd1;
          o.data_valid = 1'b1;
          o.data_byte  = b;
          total = {61'd0, p_hdr_len} + {1'b0, p_pay_len};
          if ({48'd0, p_count} >= total) begin
            o.last     = 1'b1;
            o.crc_good = (p_run_crc == p_exp_crc);
            if (o.crc_good) p_mode = MODE_IDLE;
            else latch_fault(ERR_CRC);
          end
        end
        MODE_RESYNC: begin
          if (b == BYTE_LF || b == BYTE_CR) p_mode = MODE_IDLE;
        end
        default: begin
          // Error latched: the byte is dropped.
        end
      endcase
    end
    o.opcode       = p_opcode;
    o.fault_code   = p_err;
    o.error_active = (p_err != ERR_NONE);
    return o;
  endfunction

  // Offers one item beat, with random idle cycles first, and records its expected result.
  task automatic push_item(input in_item_t it, input bit pinned, input out_item_t want);
    out_item_t pred;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item       = it;
    item_valid = 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
    pred = rx_predict(it);
    pending_results.push_back(pinned ? want : pred);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it.action  = ACT_BYTE;
    it.rx_byte = b;
    push_item(it, 1'b0, '0);
  endtask

  task automatic send_clear();
    in_item_t it;
    it.action  = ACT_CLEAR;
    it.rx_byte = 8'($urandom);
    push_item(it, 1'b0, '0);
  endtask

  // Lowers valid once the sender has nothing more to offer for now.
  task automatic release_items();
    @(negedge clk);
    item_valid = 1'b0;
  endtask

  // Waits until every expected result has arrived, plus a margin.
  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk);
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    p_limit = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Builds one frame into frame_q: header, optional payload and a correct or broken CRC.
  task automatic build_frame(input bit oversize, input bit bad_crc);
    int          form;
    int          hlen;
    int          room;
    int          pick;
    logic [63:0] target;
    logic [63:0] plen;
    logic [31:0] crc;
    frame_q.delete();
    pick = $urandom_range(0, 99);
    form = (pick < 70) ? 0 : (pick < 85) ? 1 : 2;
    hlen = (form == 0) ? 7 : (form == 1) ? 9 : 15;
    target = 64'd0;
    plen   = 64'd0;
    if (oversize) begin
      case ($urandom_range(0, 2))
        0: target = {47'd0, p_limit};
        1: target = {47'd0, p_limit} + 64'($urandom_range(1, 3000));
        default: begin
          form   = 2;
          hlen   = 15;
          target = {$urandom, $urandom} | 64'h1_0000_0000;
        end
      endcase
      plen = target - 64'(hlen);
    end else begin
      room = int'(p_limit) - hlen - 1;
      if ($urandom_range(0, 99) < 8 && room <= 600) begin
        // Largest frame that still fits under the limit.
        target = {47'd0, p_limit} - 64'd1;
        plen   = target - 64'(hlen);
      end else begin
        plen   = 64'($urandom_range(0, (room < 20) ? room : 20));
        target = plen + 64'(hlen);
      end
    end
    // Widen the length form when the chosen length does not fit it.
    if (form == 0 && plen > 64'd125) begin
      form = 1;
      hlen = 9;
      plen = target - 64'd9;
    end
    if (form == 1 && plen > 64'd65535) begin
      form = 2;
      hlen = 15;
      plen = target - 64'd15;
    end
    frame_q.push_back(BYTE_START);
    frame_q.push_back(8'($urandom));
    repeat (4) frame_q.push_back(8'h00);
    case (form)
      0: frame_q.push_back(plen[7:0]);
      1: begin
        frame_q.push_back(LEN_EXT16);
        frame_q.push_back(plen[15:8]);
        frame_q.push_back(plen[7:0]);
      end
      default: begin
        frame_q.push_back(LEN_EXT64);
        for (int i = 7; i >= 0; i--) frame_q.push_back(plen[i*8 +: 8]);
      end
    endcase
    if (!oversize) begin
      for (int i = 0; i < int'(plen); i++) frame_q.push_back(8'($urandom));
    end
    // CRC over the header with its CRC field zero, then the payload.
    crc = 32'd0;
    foreach (frame_q[i]) crc = crc32_step(crc, frame_q[i]);
    frame_q[2] = crc[31:24];
    frame_q[3] = crc[23:16];
    frame_q[4] = crc[15:8];
    frame_q[5] = crc[7:0];
    if (bad_crc) begin
      pick = 2 + $urandom_range(0, 3);
      frame_q[pick] = frame_q[pick] ^ (8'd1 << $urandom_range(0, 7));
    end
  endtask

  // Brings the receiver back to idle: clear any error or open frame, then resync.
  task automatic recover();
    logic [7:0] junk;
    while (p_mode != MODE_IDLE) begin
      if (p_mode == MODE_RESYNC) begin
        repeat ($urandom_range(0, 3)) begin
          junk = 8'($urandom);
          if (junk == BYTE_LF || junk == BYTE_CR) junk = 8'h00;
          send_byte(junk);
        end
        send_byte($urandom_range(0, 1) ? BYTE_LF : BYTE_CR);
      end else begin
        send_clear();
      end
    end
  endtask

  // One burst of random traffic: mostly well-formed frames, some broken ones and noise.
  task automatic random_burst();
    int kind;
    int cut;
    kind = $urandom_range(0, 99);
    if (kind < 62) begin
      build_frame(1'b0, $urandom_range(0, 99) < 10);
      foreach (frame_q[i]) send_byte(frame_q[i]);
    end else if (kind < 72) begin
      build_frame(1'b1, 1'b0);
      foreach (frame_q[i]) send_byte(frame_q[i]);
    end else if (kind < 82) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else if (kind < 94) begin
      // Frame cut short by a clear action.
      build_frame(1'b0, 1'b0);
      cut = $urandom_range(1, frame_q.size() - 1);
      for (int i = 0; i < cut; i++) send_byte(frame_q[i]);
      send_clear();
    end else begin
      send_clear();
    end
    if ($urandom_range(0, 99) < 30) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 3))
          0: send_byte(BYTE_SPACE);
          1: send_byte(BYTE_TAB);
          2: send_byte(BYTE_CR);
          default: send_byte(BYTE_LF);
        endcase
      end
    end
    recover();
  endtask

  function automatic out_item_t fault_result(input logic [2:0] code, input logic [3:0] opc);
    out_item_t o;
    o = '0;
    o.opcode       = opc;
    o.fault_code   = code;
    o.error_active = 1'b1;
    return o;
  endfunction

  function automatic void add_row(input logic act, input logic [7:0] b, input bit pinned,
                                  input out_item_t want);
    steer_row_t r;
    r.beat.action  = act;
    r.beat.rx_byte = b;
    r.pinned       = pinned;
    r.want         = want;
    steer_rows.push_back(r);
  endfunction

  // Directed rows: whitespace, text and bad start bytes, clear and resync, an empty
  // frame with a wrong CRC, and bytes ignored while an error is latched.
  function automatic void fill_steer_rows();
    add_row(ACT_BYTE,  BYTE_SPACE,  1'b1, '0);
    add_row(ACT_BYTE,  BYTE_TAB,    1'b0, '0);
    add_row(ACT_BYTE,  BYTE_CR,     1'b0, '0);
    add_row(ACT_BYTE,  BYTE_LF,     1'b0, '0);
    add_row(ACT_BYTE,  BYTE_LBRACK, 1'b1, fault_result(ERR_TEXT, 4'h0));
    add_row(ACT_BYTE,  8'h41,       1'b1, fault_result(ERR_TEXT, 4'h0));
    add_row(ACT_CLEAR, 8'hFF,       1'b1, '0);
    add_row(ACT_BYTE,  8'h00,       1'b0, '0);
    add_row(ACT_BYTE,  BYTE_CR,     1'b0, '0);
    add_row(ACT_BYTE,  BYTE_LBRACE, 1'b1, fault_result(ERR_TEXT, 4'h0));
    add_row(ACT_CLEAR, 8'h00,       1'b0, '0);
    add_row(ACT_BYTE,  BYTE_LF,     1'b0, '0);
    add_row(ACT_BYTE,  BYTE_START,  1'b0, '0);
    add_row(ACT_BYTE,  8'hFF,       1'b0, '0);
    repeat (4) add_row(ACT_BYTE, 8'hFF, 1'b0, '0);
    add_row(ACT_BYTE,  8'h00,       1'b0, '0);
    add_row(ACT_BYTE,  8'h55,       1'b0, '0);
    add_row(ACT_CLEAR, 8'hA5,       1'b0, '0);
    add_row(ACT_BYTE,  BYTE_CR,     1'b0, '0);
    add_row(ACT_BYTE,  8'h80,       1'b1, fault_result(ERR_BAD_START, 4'hF));
    add_row(ACT_CLEAR, 8'h5A,       1'b0, '0);
    add_row(ACT_BYTE,  BYTE_LF,     1'b0, '0);
  endfunction

  task automatic report_field(input string field, input logic [31:0] e, input logic [31:0] a);
    failures++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, a);
  endtask

  // Result monitor: every accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result beat, expected none, actual %0h", $time, result);
      end else begin
        e = pending_results.pop_front();
        if (result.data_valid != e.data_valid)
          report_field("data_valid", 32'(e.data_valid), 32'(result.data_valid));
        if (result.data_byte != e.data_byte)
          report_field("data_byte", 32'(e.data_byte), 32'(result.data_byte));
        if (result.opcode != e.opcode)
          report_field("opcode", 32'(e.opcode), 32'(result.opcode));
        if (result.last != e.last)
          report_field("last", 32'(e.last), 32'(result.last));
        if (result.crc_good != e.crc_good)
          report_field("crc_good", 32'(e.crc_good), 32'(result.crc_good));
        if (result.fault_code != e.fault_code)
          report_field("fault_code", 32'(e.fault_code), 32'(result.fault_code));
        if (result.error_active != e.error_active)
          report_field("error_active", 32'(e.error_active), 32'(result.error_active));
        if (e.last && e.crc_good) good_frames++;
        if (e.last && !e.crc_good) bad_crc_frames++;
        if (e.data_valid) payload_beats++;
        if (e.error_active) error_beats++;
      end
    end
  end

  // Receiver side: random back-pressure, and a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_ready = 1'b0;
        hold_left--;
      end else begin
        result_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Main sequence: reset, directed rows, then five phases of random traffic.
  initial begin
    logic [LIMIT_W-1:0] limits[5];
    int start;
    limits[0] = FRAME_LIMIT_RESET;
    limits[1] = LIMIT_W'(16);
    limits[2] = LIMIT_W'(65536);
    limits[3] = LIMIT_W'($urandom_range(16, 600));
    limits[4] = LIMIT_W'(200);
    reset_model();
    fill_steer_rows();
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (steer_rows[i]) push_item(steer_rows[i].beat, steer_rows[i].pinned,
                                      steer_rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        release_items();
        drain_results();
        write_limit(limits[ph]);
      end
      // Sender dense and receiver slow first, then the reverse, then no idling but one long hold-off.
      if (ph < 2) begin
        send_idle_pct = 7;
        recv_idle_pct = 84;
      end else if (ph < 4) begin
        send_idle_pct = 84;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = ~hold_req;
      end
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) random_burst();
    end

    release_items();
    drain_results();
    repeat (10) @(posedge clk);
    $display("Covered %0d item beats and %0d result beats over five frame limits.",
             items_sent, results_seen);
    $display("Frames with good CRC %0d, with bad CRC %0d; payload beats %0d, error beats %0d.",
             good_frames, bad_crc_frames, payload_beats, error_beats);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
